/* rtl/assert_macros.svh */
// assertion macros shared by the pool allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define FBPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FBPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fbpa_pkg.sv */
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int ALIGN_W        = 4;
    localparam int COUNT_W        = 11;
    localparam int STATUS_W       = 3;
    localparam int STRIDE_W       = 17;
    localparam int LEN_W          = STRIDE_W + COUNT_W;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd16;
    localparam logic [ALIGN_W-1:0] ALIGN_RST = 4'd2;
    localparam logic [COUNT_W-1:0] MAXOB_RST = 11'd1024;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_ALIGN = 2'd2;
    localparam logic [1:0] REG_MAXOB = 2'd3;

    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [SIZE_W-1:0]  object_size;
        logic [ALIGN_W-1:0] alignment_log2;
        logic [COUNT_W-1:0] max_objects;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic calc;
        logic exec;
        logic load;
    } t_cmd;

endpackage

/* rtl/fbpa_ctrl.sv */
// request sequencer and handshake control of the pool allocator
`include "assert_macros.svh"

module fbpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fbpa_pkg::t_cmd   o_cmd
);
    import fbpa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    assign o_cmd.latch = accept;
    assign o_cmd.calc  = (r_state == S_CALC);
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.load  = (r_state == S_LOAD) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_EXEC;
            S_EXEC: n_state = S_LOAD;
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `FBPA_ASSERT(a_accept_starts, i_clk, i_rst_n, accept |=> (r_state == S_CALC), "accept not followed by calc")
    `FBPA_ASSERT(a_result_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_LOAD), "result raised outside load")
    `FBPA_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !r_out_valid, "reset left result valid")

endmodule

/* rtl/fbpa_dp.sv */
// free stack, fresh block counter, arena check and result register
`include "assert_macros.svh"

module fbpa_dp #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fbpa_pkg::t_cmd                   i_cmd,
    input  fbpa_pkg::t_cfg                   i_cfg,
    input  logic                             i_mode,
    input  logic [fbpa_pkg::ADDR_W-1:0]      i_address,
    output logic [fbpa_pkg::ADDR_W-1:0]      o_block_address,
    output logic [fbpa_pkg::STATUS_W-1:0]    o_status,
    output logic [fbpa_pkg::COUNT_W-1:0]     o_remaining
);
    import fbpa_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int RW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam logic [RW-1:0] REM_MAX = RW'((1 << COUNT_W) - 1);

    logic [ADDR_W-1:0]   r_stack [POOL_DEPTH];
    logic [ADDR_W-1:0]   r_rd_data;

    logic [CW-1:0]       r_count;
    logic [COUNT_W-1:0]  r_fresh_idx;
    logic [ADDR_W-1:0]   r_fresh_off;

    logic                r_mode;
    logic [ADDR_W-1:0]   r_addr;
    logic [LEN_W-1:0]    r_len;

    logic                r_from_stack;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [STATUS_W-1:0] r_res_status;

    logic [ADDR_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_rem;

    logic [SIZE_W-1:0]   size_eff;
    logic [STRIDE_W-1:0] align;
    logic [STRIDE_W-1:0] stride;
    logic [COUNT_W-1:0]  block_cnt;
    logic [ADDR_W:0]     arena_end;
    logic                in_arena;
    logic                do_pop;
    logic                do_push;
    logic                do_fresh;
    logic [CW-1:0]       pop_cnt;
    logic [COUNT_W-1:0]  fresh_left;
    logic [RW-1:0]       rem_sum;
    logic [COUNT_W-1:0]  remaining;

    assign size_eff  = (i_cfg.object_size == '0) ? SIZE_W'(1) : i_cfg.object_size;
    assign align     = STRIDE_W'(1) << i_cfg.alignment_log2;
    assign stride    = (STRIDE_W'(size_eff) + align - STRIDE_W'(1)) & ~(align - STRIDE_W'(1));
    assign block_cnt = (32'(i_cfg.max_objects) > 32'(POOL_DEPTH)) ?
                       COUNT_W'(POOL_DEPTH) : i_cfg.max_objects;

    assign arena_end = {1'b0, i_cfg.base_address} + (ADDR_W + 1)'(r_len);
    assign in_arena  = (r_addr != '0) && (r_addr >= i_cfg.base_address) &&
                       ({1'b0, r_addr} < arena_end);

    assign do_pop   = (r_mode == MODE_ALLOC) && (r_count != '0);
    assign do_fresh = (r_mode == MODE_ALLOC) && (r_count == '0) && (r_fresh_idx < block_cnt);
    assign do_push  = (r_mode != MODE_ALLOC) && in_arena && (r_count != CW'(POOL_DEPTH));
    assign pop_cnt  = r_count - CW'(1);

    assign fresh_left = (r_fresh_idx < block_cnt) ? (block_cnt - r_fresh_idx) : '0;
    assign rem_sum    = RW'(fresh_left) + RW'(r_count);
    assign remaining  = (rem_sum > REM_MAX) ? REM_MAX[COUNT_W-1:0] : rem_sum[COUNT_W-1:0];

    // request capture and arena length
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_addr <= i_address;
        end
        if (i_cmd.calc) begin
            r_len <= LEN_W'(stride) * LEN_W'(block_cnt);
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) begin
            r_stack[r_count[AW-1:0]] <= r_addr;
        end
        if (i_cmd.exec && do_pop) begin
            r_rd_data <= r_stack[pop_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fresh_idx <= '0;
            r_fresh_off <= '0;
        end else if (i_cmd.exec) begin
            if (do_pop) begin
                r_count <= pop_cnt;
            end else if (do_push) begin
                r_count <= r_count + CW'(1);
            end
            if (do_fresh) begin
                r_fresh_idx <= r_fresh_idx + COUNT_W'(1);
                r_fresh_off <= r_fresh_off + ADDR_W'(stride);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_from_stack <= do_pop;
            r_res_addr   <= do_fresh ? (i_cfg.base_address + r_fresh_off) : '0;
            priority if (r_mode == MODE_ALLOC) begin
                r_res_status <= (do_pop || do_fresh) ? ST_GRANTED : ST_EMPTY;
            end else if (!in_arena) begin
                r_res_status <= ST_IGNORED;
            end else if (!do_push) begin
                r_res_status <= ST_DROPPED;
            end else begin
                r_res_status <= ST_FREED;
            end
        end
        if (i_cmd.load) begin
            r_out_addr   <= r_from_stack ? r_rd_data : r_res_addr;
            r_out_status <= r_res_status;
            r_out_rem    <= remaining;
        end
    end

    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_remaining     = r_out_rem;

    `FBPA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(POOL_DEPTH), "free stack count beyond depth")
    `FBPA_ASSERT(a_count_moves_on_exec, i_clk, i_rst_n, !$past(i_cmd.exec) |-> $stable(r_count), "stack count moved outside execute")

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: LIFO free stack in front of an ascending fresh-block counter.
// An accepted request passes the capture, arena multiply, execute with registered stack
// read, and result load steps of the sequencer before its result is valid; the load step
// waits while the output is stalled, and no new request is taken until that load is done.
// Reset: config registers return to their defaults, stack count and fresh counters clear;
// stack contents are not cleared and no clearing pass runs.
module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]      paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]      pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fbpa_pkg::ADDR_W-1:0]       o_block_address,
    output logic [fbpa_pkg::STATUS_W-1:0]     o_status,
    output logic [fbpa_pkg::COUNT_W-1:0]      o_remaining
);
    import fbpa_pkg::*;

    t_cfg       r_cfg;
    t_cmd       cmd;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address   <= BASE_RST;
            r_cfg.object_size    <= SIZE_RST;
            r_cfg.alignment_log2 <= ALIGN_RST;
            r_cfg.max_objects    <= MAXOB_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BASE:  r_cfg.base_address   <= pwdata[ADDR_W-1:0];
                REG_SIZE:  r_cfg.object_size    <= pwdata[SIZE_W-1:0];
                REG_ALIGN: r_cfg.alignment_log2 <= pwdata[ALIGN_W-1:0];
                REG_MAXOB: r_cfg.max_objects    <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BASE:  prdata = PDATA_W'(r_cfg.base_address);
            REG_SIZE:  prdata = PDATA_W'(r_cfg.object_size);
            REG_ALIGN: prdata = PDATA_W'(r_cfg.alignment_log2);
            REG_MAXOB: prdata = PDATA_W'(r_cfg.max_objects);
            default:   prdata = '0;
        endcase
    end

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fbpa_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (r_cfg),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .o_remaining     (o_remaining)
    );

endmodule
